FILE: rtl/core/vpc_pkg.sv
// shared types, codes and tables of the volume potentiometer controller
`default_nettype none

package vpc_pkg;

  localparam int DELAY_W = 10;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd500;

  localparam int NUM_LEVELS = 8;
  localparam logic [3:0] LVL_MAX = 4'(NUM_LEVELS - 1);

  // input event codes
  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_ENABLE    = 3'd1;
  localparam logic [2:0] KIND_DISABLE   = 3'd2;
  localparam logic [2:0] KIND_SET_MODE  = 3'd3;
  localparam logic [2:0] KIND_SET_LEVEL = 3'd4;
  localparam logic [2:0] KIND_QUERY     = 3'd5;
  localparam logic [2:0] KIND_PRELOAD   = 3'd6;

  // result codes
  localparam logic [1:0] OUT_SPI    = 2'd0;
  localparam logic [1:0] OUT_STORE  = 2'd1;
  localparam logic [1:0] OUT_REPORT = 2'd2;

  // pot command bytes
  localparam logic [7:0] SPI_TCON     = 8'h40;
  localparam logic [7:0] SPI_SHUTDOWN = 8'h07;
  localparam logic [7:0] SPI_WAKE     = 8'h0F;

  typedef enum logic [1:0] {
    POT_NONE,
    POT_SHUT,
    POT_WIPER,
    POT_WIPER_ON
  } pot_op_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_STORE,
    TAIL_REPORT
  } tail_t;

  // one classified event: an optional pot frame first, then an optional store or report
  typedef struct packed {
    pot_op_t    pot_op;
    logic [2:0] pot_lvl;
    tail_t      tail;
    logic [1:0] tail_mode;
    logic [3:0] tail_level;
  } cmd_t;

  function automatic logic [8:0] wiper_pos(input logic [2:0] lvl);
    logic [8:0] w;
    unique case (lvl)
      3'd0:    w = 9'd0;
      3'd1:    w = 9'd0;
      3'd2:    w = 9'd12;
      3'd3:    w = 9'd28;
      3'd4:    w = 9'd64;
      3'd5:    w = 9'd104;
      3'd6:    w = 9'd160;
      3'd7:    w = 9'd256;
      default: w = 9'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vpc_intf.sv
// request and result channel interfaces of the volume potentiometer controller
`default_nettype none

interface vpc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [1:0] mode;
  logic [3:0] level;

  modport source (output valid, output kind, output mode, output level, input ready);
  modport sink   (input valid, input kind, input mode, input level, output ready);
endinterface

interface vpc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] spi_byte;
  logic       frame_end;
  logic [1:0] store_mode;
  logic [3:0] level_value;
  logic       last;

  modport source (output valid, output out_kind, output spi_byte, output frame_end,
                  output store_mode, output level_value, output last, input ready);
  modport sink   (input valid, input out_kind, input spi_byte, input frame_end,
                  input store_mode, input level_value, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/vpc_front.sv
// front end: accepts requests, keeps the controller state, classifies into commands
`default_nettype none

module vpc_front #(
  parameter int NUM_MODES = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [vpc_pkg::DELAY_W-1:0] cfg_wdata,
  vpc_item_if.sink                    item,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output vpc_pkg::cmd_t               push_cmd
);
  import vpc_pkg::*;

  localparam int MW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

  logic [DELAY_W-1:0] store_delay;
  logic               enabled, enabled_next;
  logic [3:0]         pot_level, pot_level_next;
  logic [1:0]         active_mode, active_mode_next;
  logic               store_pending, store_pending_next;
  logic [1:0]         pending_mode, pending_mode_next;
  logic [3:0]         pending_level, pending_level_next;
  logic [DELAY_W-1:0] countdown, countdown_next;
  logic [3:0]         stored_levels [NUM_MODES];

  logic       accept;
  logic       mode_ok;
  logic [1:0] rd_mode;
  logic [3:0] eff_level;
  logic       wr_en;
  logic [1:0] wr_mode;
  logic [3:0] wr_level;
  logic       pot_do;
  logic [3:0] pot_tgt;
  logic [3:0] pot_clamped;
  cmd_t       cmd;

  assign accept  = item.valid && push_ready;
  assign item.ready = push_ready;
  assign mode_ok = (int'(item.mode) < NUM_MODES);

  // effective level of the addressed mode: a pending store wins over the mirror
  assign rd_mode   = (item.kind == KIND_ENABLE) ? active_mode : item.mode;
  assign eff_level = (store_pending && rd_mode == pending_mode) ? pending_level
                                                               : stored_levels[MW'(rd_mode)];

  always_comb begin
    enabled_next       = enabled;
    active_mode_next   = active_mode;
    store_pending_next = store_pending;
    pending_mode_next  = pending_mode;
    pending_level_next = pending_level;
    countdown_next     = countdown;
    pot_level_next     = pot_level;
    wr_en    = 1'b0;
    wr_mode  = pending_mode;
    wr_level = pending_level;
    pot_do   = 1'b0;
    pot_tgt  = 4'd0;
    cmd.pot_op     = POT_NONE;
    cmd.pot_lvl    = 3'd0;
    cmd.tail       = TAIL_NONE;
    cmd.tail_mode  = 2'd0;
    cmd.tail_level = 4'd0;

    unique case (item.kind)
      KIND_TICK: begin
        if (store_pending) begin
          if (countdown <= DELAY_W'(1)) begin
            countdown_next     = '0;
            store_pending_next = 1'b0;
            wr_en              = 1'b1;
            cmd.tail           = TAIL_STORE;
            cmd.tail_mode      = pending_mode;
            cmd.tail_level     = pending_level;
          end else begin
            countdown_next = countdown - DELAY_W'(1);
          end
        end
      end
      KIND_ENABLE: begin
        enabled_next = 1'b1;
        pot_do       = 1'b1;
        pot_tgt      = eff_level;
      end
      KIND_DISABLE: begin
        enabled_next = 1'b0;
        pot_do       = 1'b1;
        pot_tgt      = 4'd0;
      end
      KIND_SET_MODE: begin
        if (mode_ok && item.mode != active_mode) begin
          active_mode_next = item.mode;
          pot_do           = enabled;
          pot_tgt          = eff_level;
        end
      end
      KIND_SET_LEVEL: begin
        if (mode_ok) begin
          pot_do  = enabled && item.mode == active_mode;
          pot_tgt = item.level;
          // a pending store of another mode is flushed right away
          if (store_pending && item.mode != pending_mode) begin
            wr_en          = 1'b1;
            cmd.tail       = TAIL_STORE;
            cmd.tail_mode  = pending_mode;
            cmd.tail_level = pending_level;
          end
          pending_mode_next  = item.mode;
          pending_level_next = item.level;
          countdown_next     = store_delay;
          store_pending_next = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (mode_ok) begin
          cmd.tail       = TAIL_REPORT;
          cmd.tail_level = eff_level;
        end
      end
      KIND_PRELOAD: begin
        if (mode_ok) begin
          wr_en    = 1'b1;
          wr_mode  = item.mode;
          wr_level = item.level;
        end
      end
      default: ;
    endcase

    // pot sees the clamped level only, and only when it changes
    pot_clamped = (pot_tgt > LVL_MAX) ? LVL_MAX : pot_tgt;
    if (pot_do && pot_clamped != pot_level) begin
      pot_level_next = pot_clamped;
      cmd.pot_lvl    = pot_clamped[2:0];
      if (pot_clamped == 4'd0) begin
        cmd.pot_op = POT_SHUT;
      end else if (pot_level == 4'd0) begin
        cmd.pot_op = POT_WIPER_ON;
      end else begin
        cmd.pot_op = POT_WIPER;
      end
    end
  end

  assign push_valid = accept && (cmd.pot_op != POT_NONE || cmd.tail != TAIL_NONE);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      store_delay   <= DELAY_RESET;
      enabled       <= 1'b0;
      pot_level     <= 4'd15;
      active_mode   <= 2'd0;
      store_pending <= 1'b0;
      pending_mode  <= 2'd0;
      pending_level <= 4'd0;
      countdown     <= '0;
      for (int i = 0; i < NUM_MODES; i++) begin
        stored_levels[i] <= 4'd0;
      end
    end else begin
      if (cfg_we) begin
        store_delay <= cfg_wdata;
      end
      if (accept) begin
        enabled       <= enabled_next;
        pot_level     <= pot_level_next;
        active_mode   <= active_mode_next;
        store_pending <= store_pending_next;
        pending_mode  <= pending_mode_next;
        pending_level <= pending_level_next;
        countdown     <= countdown_next;
        if (wr_en) begin
          stored_levels[MW'(wr_mode)] <= wr_level;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vpc_queue.sv
// two-entry command queue between front and back
`default_nettype none

module vpc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  vpc_pkg::cmd_t      push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output vpc_pkg::cmd_t      pop_cmd
);
  import vpc_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vpc_back.sv
// back end: expands one command into its result sequence, one result per cycle while the result channel is not stalled
`default_nettype none

module vpc_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     pop_valid,
  output logic          pop_ready,
  input  vpc_pkg::cmd_t pop_cmd,
  vpc_result_if.source  result
);
  import vpc_pkg::*;

  logic [2:0] step;
  logic [2:0] n_pot;
  logic [2:0] n_total;
  logic       fire;
  logic       is_last;
  logic [8:0] wiper;
  logic [1:0] r_kind;
  logic [7:0] r_byte;
  logic       r_fend;
  logic [1:0] r_mode;
  logic [3:0] r_level;

  always_comb begin
    case (pop_cmd.pot_op)
      POT_SHUT, POT_WIPER: n_pot = 3'd2;
      POT_WIPER_ON:        n_pot = 3'd4;
      default:             n_pot = 3'd0;
    endcase
  end

  assign n_total = n_pot + ((pop_cmd.tail != TAIL_NONE) ? 3'd1 : 3'd0);
  assign is_last = (step == n_total - 3'd1);
  assign wiper   = wiper_pos(pop_cmd.pot_lvl);
  assign fire    = pop_valid && (!result.valid || result.ready);
  assign pop_ready = fire && is_last;

  always_comb begin
    r_kind  = OUT_SPI;
    r_byte  = 8'd0;
    r_fend  = 1'b0;
    r_mode  = 2'd0;
    r_level = 4'd0;
    if (step < n_pot) begin
      if (pop_cmd.pot_op == POT_SHUT) begin
        r_byte = (step == 3'd0) ? SPI_TCON : SPI_SHUTDOWN;
        r_fend = (step == 3'd1);
      end else begin
        case (step)
          3'd0:    r_byte = {7'd0, wiper[8]};
          3'd1:    r_byte = wiper[7:0];
          3'd2:    r_byte = SPI_TCON;
          default: r_byte = SPI_WAKE;
        endcase
        r_fend = (step == n_pot - 3'd1);
      end
    end else if (pop_cmd.tail == TAIL_STORE) begin
      r_kind  = OUT_STORE;
      r_mode  = pop_cmd.tail_mode;
      r_level = pop_cmd.tail_level;
    end else begin
      r_kind  = OUT_REPORT;
      r_level = pop_cmd.tail_level;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.out_kind    <= r_kind;
      result.spi_byte    <= r_byte;
      result.frame_end   <= r_fend;
      result.store_mode  <= r_mode;
      result.level_value <= r_level;
      result.last        <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      step         <= 3'd0;
    end else begin
      if (fire) begin
        result.valid <= 1'b1;
        step         <= is_last ? 3'd0 : step + 3'd1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> (step < n_total))
    else $error("result step beyond command length");

  a_spi_no_store_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.out_kind == OUT_SPI) |->
      (result.store_mode == 2'd0 && result.level_value == 4'd0))
    else $error("spi byte carries store fields");

  a_frame_end_on_spi: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_end) |-> (result.out_kind == OUT_SPI))
    else $error("frame end on a non-spi result");

  a_step_clears_on_pop: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (step == 3'd0))
    else $error("step not cleared after command done");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/volume_pot_controller.sv
// top level of the volume potentiometer controller
`default_nettype none

// Volume potentiometer controller. Each request (tick, enable, disable, set
// mode, set level, query level, preload stored level) is taken by the front
// end: it updates the enable flag, active mode, potentiometer level, the
// per-mode level mirror and the single deferred store with its tick countdown,
// and turns the request into a compact command. A two-entry queue hands
// commands to the back end, which emits results one per cycle when not stalled:
// SPI bytes (frame_end marks the byte after which chip select rises), store
// requests and level reports, with last set on the final result of a request. A
// request that gives no result leaves nothing in the queue. The front takes a
// request every cycle while the queue has room; a request gives up to five
// results (four SPI bytes plus a store request), so the sustained rate is set
// by the back end's result count. Levels above the top wiper step are kept and
// reported in full but clamped at the pot. The store delay register (reset 500
// ticks, zero acts as one) is to be written through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce this. After reset the pot level
// counts as unknown, so a first disable still sends a shutdown frame.
module volume_pot_controller #(
  parameter int NUM_MODES = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [vpc_pkg::DELAY_W-1:0] cfg_wdata,
  vpc_item_if.sink                         item,
  vpc_result_if.source                     result
);
  import vpc_pkg::*;

  // front to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // classify requests and keep all controller state
  vpc_front #(
    .NUM_MODES (NUM_MODES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouples request intake from result delivery
  vpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // serialize each command into its results, registered output
  vpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .result    (result)
  );

endmodule

`default_nettype wire
